>>> hw/rtl/rrp_pkg.sv
package rrp_pkg;

    localparam int ANG_W = 16;
    localparam int LEN_W = 20;
    localparam int TRIG_W = 18;
    localparam int VAL_W = 21;
    localparam int PROD_W = 21;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 21'sd1048575;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -21'sd1048576;
    localparam logic signed [VAL_W-1:0] ONE_Q16 = 21'sd65536;

    localparam logic [1:0] SEL_POSE = 2'd0;
    localparam logic [1:0] SEL_JAC = 2'd1;
    localparam logic [1:0] SEL_BOTH = 2'd2;
    localparam logic [1:0] SEL_SPARE = 2'd3;

    localparam logic [1:0] REG_TOOL = 2'd0;
    localparam logic [1:0] REG_BASE = 2'd1;
    localparam logic [1:0] REG_SEL = 2'd2;

    // Angle-stage state handed to the product stage
    typedef struct packed {
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s2;
        logic signed [TRIG_W-1:0] c2;
        logic signed [LEN_W-1:0] len;
        logic [17:0] base;
        logic [1:0] sel;
    } trig_t;

    // All products of one joint vector
    typedef struct packed {
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s2;
        logic signed [TRIG_W-1:0] c2;
        logic signed [PROD_W-1:0] c1c2;
        logic signed [PROD_W-1:0] s1c2;
        logic signed [PROD_W-1:0] s2c1;
        logic signed [PROD_W-1:0] s1s2;
        logic signed [LEN_W-1:0] len;
        logic [17:0] base;
        logic [1:0] sel;
    } prod_t;

    typedef struct packed {
        logic signed [37:0] l_s2c1;
        logic signed [37:0] l_s1s2;
        logic signed [37:0] l_c2;
        logic signed [37:0] l_c1c2;
        logic signed [37:0] l_s1c2;
        logic signed [37:0] l_s2;
    } lprod_t;

    // Round half up a Q32 product back to Q16
    function automatic logic signed [37:0] rnd_q16(input logic signed [53:0] p);
        logic signed [53:0] t;
        t = p + 54'sd32768;
        return t[53:16];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat(input logic signed [39:0] v);
        if (v > 40'(VAL_MAX)) return VAL_MAX;
        else if (v < 40'(VAL_MIN)) return VAL_MIN;
        else return v[VAL_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rrp_sincos.sv
module rrp_sincos
    import rrp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ANG_W-1:0]         ang,
    output logic signed [TRIG_W-1:0] sin_out
);

    // Three register stages of the quarter-wave polynomial; the final
    // multiply is left to the register stage that follows this module
    logic [15:0] z_reg, z2_reg, z_p_reg, z2b_reg, z_q_reg;
    logic [16:0] t_reg;
    logic [17:0] t2_reg;
    logic top_reg, top2_reg, top3_reg;
    logic neg_reg, neg2_reg, neg3_reg;
    logic [15:0] x_next;
    logic [15:0] z_next;
    logic [31:0] z2w;
    logic [31:0] m1;
    logic [16:0] t1;
    logic [33:0] m2;
    logic [17:0] t2;
    logic [35:0] m3;
    logic signed [TRIG_W-1:0] r;

    // Fold the angle into the first quadrant and square it
    always_comb begin
        x_next = ang[14] ? (16'd16384 - {2'b00, ang[13:0]}) : {2'b00, ang[13:0]};
        z_next = {x_next[13:0], 2'b00};
        if (x_next[14]) z_next = 16'd0;
        z2w = 32'(z_next) * 32'(z_next);
        if (x_next[14]) z2w = 32'd0;
    end

    // Inner and middle polynomial terms
    always_comb begin
        m1 = 32'(z2_reg) * 32'd9279;
        t1 = 17'd84095 - 17'(m1 >> 16);
        m2 = 34'(t_reg) * 34'(z2b_reg);
        t2 = 18'd205887 - 18'(m2 >> 16);
    end

    // z = 65536 is reached only at x = 16384; carry it as the top flag
    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= z_next;
            z2_reg <= z2w[31:16];
            top_reg <= x_next[14];
            neg_reg <= ang[15];
            t_reg <= t1;
            z_p_reg <= z_reg;
            z2b_reg <= z2_reg;
            top2_reg <= top_reg;
            neg2_reg <= neg_reg;
            t2_reg <= t2;
            z_q_reg <= z_p_reg;
            top3_reg <= top2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // Outer multiply with rounding, then apply the sign
    always_comb begin
        m3 = 36'(z_q_reg) * 36'(t2_reg) + 36'd65536;
        r = top3_reg ? TRIG_W'(65536) : TRIG_W'(m3 >> 17);
        sin_out = neg3_reg ? -r : r;
    end

endmodule

>>> hw/rtl/rrp_products.sv
module rrp_products
    import rrp_pkg::*;
(
    input  logic   aclk,
    input  logic   en,
    input  trig_t  in_t,
    output prod_t  prod,
    output lprod_t lp
);

    // Trig products, rounded to Q16
    prod_t p_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg.s1 <= in_t.s1;
            p_reg.c1 <= in_t.c1;
            p_reg.s2 <= in_t.s2;
            p_reg.c2 <= in_t.c2;
            p_reg.c1c2 <= PROD_W'(rnd_q16(54'(in_t.c1) * 54'(in_t.c2)));
            p_reg.s1c2 <= PROD_W'(rnd_q16(54'(in_t.s1) * 54'(in_t.c2)));
            p_reg.s2c1 <= PROD_W'(rnd_q16(54'(in_t.s2) * 54'(in_t.c1)));
            p_reg.s1s2 <= PROD_W'(rnd_q16(54'(in_t.s1) * 54'(in_t.s2)));
            p_reg.len <= in_t.len;
            p_reg.base <= in_t.base;
            p_reg.sel <= in_t.sel;
        end
    end

    // Length times each product
    always_ff @(posedge aclk) begin
        if (en) begin
            prod <= p_reg;
            lp.l_s2c1 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.s2c1));
            lp.l_s1s2 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.s1s2));
            lp.l_c2 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.c2));
            lp.l_c1c2 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.c1c2));
            lp.l_s1c2 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.s1c2));
            lp.l_s2 <= rnd_q16(54'(p_reg.len) * 54'(p_reg.s2));
        end
    end

endmodule

>>> hw/rtl/rrp_turret_pose_and_jacobian.sv
// Forward pose and wrist Jacobian of a two-revolute, one-prismatic turret.
// Input transfer on s_axis: tdata holds shoulder_angle [15:0],
// elbow_angle [31:16], extension [50:32]. Each joint vector produces up to
// nine rows on m_axis: three pose rows, six Jacobian rows, or both.
// Output tdata holds value_a..value_d, 21 bits each from bit 0; tuser holds
// matrix_id [0] and row_index [3:1]; tlast marks the last row of a vector.
// m_tvalid rises once the input transfer has passed through seven register
// stages (three sine stages, the final sine multiply, two product stages
// and the row register).
// Throughput is one row per cycle while m_tready is high: a vector gives
// three, six or nine rows, sent one at a time by the row emitter.
// s_tready falls while a vector waits at the end of the pipeline and the
// emitter still has rows to send; it rises when the last row moves out.
// The pipeline holds behind a waiting vector, so no row is lost.
// Reset clears valid bits and loads the register defaults:
// tool offset 0.1 m, base height 0.5 m, both matrices. Writes go through
// cfg_we/cfg_addr/cfg_wdata, by the user only while idle; unenforced.
module rrp_turret_pose_and_jacobian
    import rrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // shoulder_angle, elbow_angle, extension
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // value_a, value_b, value_c, value_d
    output logic [3:0]  m_tuser,   // matrix_id, row_index
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [17:0] cfg_wdata
);

    logic [17:0] tool_reg, base_reg;
    logic [1:0] sel_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tool_reg <= 18'd6554;
            base_reg <= 18'd32768;
            sel_reg <= SEL_BOTH;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TOOL: tool_reg <= cfg_wdata;
                REG_BASE: base_reg <= cfg_wdata;
                REG_SEL:  sel_reg <= cfg_wdata[1:0];
                default:  ;
            endcase
        end
    end

    // Pipeline advances when no vector waits at its end or the emitter can take one
    logic [5:0] vld_reg;
    logic emit_busy;
    logic load;
    logic en;
    assign en = !vld_reg[5] || load;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[4:0], s_tvalid};
    end

    logic signed [TRIG_W-1:0] s1, c1, s2, c2;
    rrp_sincos u_s1 (.aclk, .en, .ang(s_tdata[15:0]), .sin_out(s1));
    rrp_sincos u_c1 (.aclk, .en, .ang(s_tdata[15:0] + 16'd16384), .sin_out(c1));
    rrp_sincos u_s2 (.aclk, .en, .ang(s_tdata[31:16]), .sin_out(s2));
    rrp_sincos u_c2 (.aclk, .en, .ang(s_tdata[31:16] + 16'd16384), .sin_out(c2));

    // Length through three delay stages alongside the sine pipeline
    logic signed [LEN_W-1:0] len_d_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            len_d_reg[0] <= LEN_W'($signed(s_tdata[50:32])) + LEN_W'(tool_reg);
            len_d_reg[1] <= len_d_reg[0];
            len_d_reg[2] <= len_d_reg[1];
        end
    end

    trig_t t_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg.s1 <= s1;
            t_reg.c1 <= c1;
            t_reg.s2 <= s2;
            t_reg.c2 <= c2;
            t_reg.len <= len_d_reg[2];
            t_reg.base <= base_reg;
            t_reg.sel <= sel_reg;
        end
    end

    prod_t pr;
    lprod_t lp;
    rrp_products u_prod (.aclk, .en, .in_t(t_reg), .prod(pr), .lp(lp));

    // Row emitter: latch a vector, step through its rows
    prod_t e_reg;
    lprod_t el_reg;
    logic [3:0] row_reg;
    logic [3:0] last_reg;
    logic out_v_reg;

    assign emit_busy = out_v_reg && !(m_tready && row_reg == last_reg);
    assign load = !emit_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            row_reg <= '0;
            last_reg <= '0;
        end else if (load) begin
            out_v_reg <= vld_reg[5];
            if (vld_reg[5]) begin
                e_reg <= pr;
                el_reg <= lp;
                row_reg <= (pr.sel == SEL_JAC) ? 4'd3 : 4'd0;
                last_reg <= (pr.sel == SEL_POSE) ? 4'd2 : 4'd8;
            end
        end else if (m_tready) begin
            row_reg <= row_reg + 4'd1;
        end
    end

    logic signed [39:0] va, vb, vc, vd;
    always_comb begin
        va = '0; vb = '0; vc = '0; vd = '0;
        case (row_reg)
            4'd0: begin
                va = 40'(e_reg.c1c2); vb = -40'(e_reg.s1);
                vc = -40'(e_reg.s2c1); vd = -40'(el_reg.l_s2c1);
            end
            4'd1: begin
                va = 40'(e_reg.s1c2); vb = 40'(e_reg.c1);
                vc = -40'(e_reg.s1s2); vd = -40'(el_reg.l_s1s2);
            end
            4'd2: begin
                va = 40'(e_reg.s2); vc = 40'(e_reg.c2);
                vd = 40'($signed({1'b0, e_reg.base})) + 40'(el_reg.l_c2);
            end
            4'd3: begin
                va = 40'(el_reg.l_s1s2); vb = -40'(el_reg.l_c1c2);
                vc = -40'(e_reg.s2c1);
            end
            4'd4: begin
                va = -40'(el_reg.l_s2c1); vb = -40'(el_reg.l_s1c2);
                vc = -40'(e_reg.s1s2);
            end
            4'd5: begin vb = -40'(el_reg.l_s2); vc = 40'(e_reg.c2); end
            4'd6: vb = 40'(e_reg.s1);
            4'd7: vb = -40'(e_reg.c1);
            4'd8: va = 40'(ONE_Q16);
            default: ;
        endcase
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {4'd0, sat(vd), sat(vc), sat(vb), sat(va)};
    assign m_tuser = (row_reg >= 4'd3) ? {3'(row_reg - 4'd3), 1'b1}
                                       : {row_reg[2:0], 1'b0};
    assign m_tlast = row_reg == last_reg;

endmodule
